// ----- design/rcpw_pkg.sv -----
package rcpw_pkg;

  // Number of level and width fields on the ports
  localparam int PIN_FIELDS = 4;
  localparam int CHANNELS_DEF = 4;

  localparam int US_W = 16;
  localparam int STAMP_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [US_W-1:0] CAPTURE_MIN_RST = 16'd500;
  localparam logic [US_W-1:0] CAPTURE_MAX_RST = 16'd2500;
  localparam logic [US_W-1:0] CLAMP_MIN_RST = 16'd1000;
  localparam logic [US_W-1:0] CLAMP_MAX_RST = 16'd2000;
  localparam logic [US_W-1:0] NEUTRAL_RST = 16'd1500;
  localparam logic [STAMP_W-1:0] LOST_TIMEOUT_RST = 32'd100000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPTURE_MIN  = 3'd0,
    REG_CAPTURE_MAX  = 3'd1,
    REG_CLAMP_MIN    = 3'd2,
    REG_CLAMP_MAX    = 3'd3,
    REG_NEUTRAL      = 3'd4,
    REG_LOST_TIMEOUT = 3'd5
  } reg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_READ   = 1'b1
  } action_e;

  typedef struct packed {
    logic [US_W-1:0]    capture_min;
    logic [US_W-1:0]    capture_max;
    logic [US_W-1:0]    clamp_min;
    logic [US_W-1:0]    clamp_max;
    logic [US_W-1:0]    neutral;
    logic [STAMP_W-1:0] lost_timeout;
  } cfg_t;

  typedef struct packed {
    logic            lost;
    logic [US_W-1:0] width;
  } lane_res_t;

  typedef struct packed {
    logic [PIN_FIELDS-1:0][US_W-1:0] width;
    logic                            healthy;
  } result_t;

endpackage

// ----- design/rcpw_lane.sv -----
module rcpw_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        sample_i,
  input  logic [rcpw_pkg::STAMP_W-1:0] now_us_i,
  input  logic                        level_i,
  input  rcpw_pkg::cfg_t              cfg_i,
  output rcpw_pkg::lane_res_t         res_o
);
  import rcpw_pkg::*;

  logic               prev_level_q, prev_level_d;
  logic [STAMP_W-1:0] rise_stamp_q, rise_stamp_d;
  logic [US_W-1:0]    held_width_q, held_width_d;
  logic [STAMP_W-1:0] pulse_stamp_q, pulse_stamp_d;
  logic               held_valid_q, held_valid_d;

  logic [STAMP_W-1:0] pulse_len;
  logic [STAMP_W-1:0] age;
  logic               fall_ok;
  logic               in_window;

  assign pulse_len = now_us_i - rise_stamp_q;
  assign fall_ok   = now_us_i > rise_stamp_q;
  assign in_window = (pulse_len >= {{(STAMP_W-US_W){1'b0}}, cfg_i.capture_min}) &&
                     (pulse_len <= {{(STAMP_W-US_W){1'b0}}, cfg_i.capture_max});

  always_comb begin
    prev_level_d  = prev_level_q;
    rise_stamp_d  = rise_stamp_q;
    held_width_d  = held_width_q;
    pulse_stamp_d = pulse_stamp_q;
    held_valid_d  = held_valid_q;
    if (sample_i) begin
      prev_level_d = level_i;
      if (level_i && !prev_level_q) begin
        rise_stamp_d = now_us_i;
      end else if (!level_i && prev_level_q && fall_ok && in_window) begin
        held_width_d  = pulse_len[US_W-1:0];
        pulse_stamp_d = now_us_i;
        held_valid_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q  <= 1'b0;
      rise_stamp_q  <= '0;
      held_width_q  <= NEUTRAL_RST;
      pulse_stamp_q <= '0;
      held_valid_q  <= 1'b0;
    end else begin
      prev_level_q  <= prev_level_d;
      rise_stamp_q  <= rise_stamp_d;
      held_width_q  <= held_width_d;
      pulse_stamp_q <= pulse_stamp_d;
      held_valid_q  <= held_valid_d;
    end
  end

  // Read side: age wraps modulo 2^32; clamp_min is checked before clamp_max
  assign age = now_us_i - pulse_stamp_q;

  always_comb begin
    res_o.lost = !held_valid_q || (age > cfg_i.lost_timeout);
    if (res_o.lost) begin
      res_o.width = cfg_i.neutral;
    end else if (held_width_q < cfg_i.clamp_min) begin
      res_o.width = cfg_i.clamp_min;
    end else if (held_width_q > cfg_i.clamp_max) begin
      res_o.width = cfg_i.clamp_max;
    end else begin
      res_o.width = held_width_q;
    end
  end

endmodule

// ----- design/rcpw_merge.sv -----
module rcpw_merge (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         push_i,
  input  rcpw_pkg::lane_res_t [rcpw_pkg::PIN_FIELDS-1:0] lane_res_i,
  input  logic                                         out_stall_i,
  output logic                                         out_valid_o,
  output logic                                         skid_full_o,
  output rcpw_pkg::result_t                            result_o
);
  import rcpw_pkg::*;

  result_t merged;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    out_free;

  always_comb begin
    merged.healthy = 1'b1;
    for (int i = 0; i < PIN_FIELDS; i++) begin
      merged.width[i] = lane_res_i[i].width;
      if (lane_res_i[i].lost) begin
        merged.healthy = 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      // drain the skid item first; input is stalled while it is full
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        out_d       = merged;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push_i) begin
      skid_d       = merged;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign skid_full_o = skid_valid_q;
  assign result_o    = out_q;

endmodule

// ----- design/rc_pulse_width_capture.sv -----
// A read item's result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one item per cycle while in_stall_o is low, samples and reads mixed freely; each lane
//   does its edge capture and its age/clamp check in the cycle of acceptance.
// A two-entry output stage (register plus skid) holds results under stall.
// Reset (async, active low) resets all lane state and loads register defaults.
module rc_pulse_width_capture #(
  parameter int CHANNELS = rcpw_pkg::CHANNELS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [rcpw_pkg::STAMP_W-1:0]    now_us_i,
  input  logic                            level_a_i,
  input  logic                            level_b_i,
  input  logic                            level_c_i,
  input  logic                            level_d_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rcpw_pkg::US_W-1:0]       width_a_o,
  output logic [rcpw_pkg::US_W-1:0]       width_b_o,
  output logic [rcpw_pkg::US_W-1:0]       width_c_o,
  output logic [rcpw_pkg::US_W-1:0]       width_d_o,
  output logic                            healthy_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rcpw_pkg::*;

  localparam int LANES = (CHANNELS < PIN_FIELDS) ? CHANNELS : PIN_FIELDS;

  cfg_t                       cfg_q, cfg_d;
  logic [PIN_FIELDS-1:0]      levels;
  lane_res_t [PIN_FIELDS-1:0] lane_res;
  result_t                    result;
  logic                       in_fire;
  logic                       sample_fire;
  logic                       read_fire;
  logic                       skid_full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CAPTURE_MIN:  cfg_d.capture_min  = cfg_data_i[US_W-1:0];
        REG_CAPTURE_MAX:  cfg_d.capture_max  = cfg_data_i[US_W-1:0];
        REG_CLAMP_MIN:    cfg_d.clamp_min    = cfg_data_i[US_W-1:0];
        REG_CLAMP_MAX:    cfg_d.clamp_max    = cfg_data_i[US_W-1:0];
        REG_NEUTRAL:      cfg_d.neutral      = cfg_data_i[US_W-1:0];
        REG_LOST_TIMEOUT: cfg_d.lost_timeout = cfg_data_i[STAMP_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_min  <= CAPTURE_MIN_RST;
      cfg_q.capture_max  <= CAPTURE_MAX_RST;
      cfg_q.clamp_min    <= CLAMP_MIN_RST;
      cfg_q.clamp_max    <= CLAMP_MAX_RST;
      cfg_q.neutral      <= NEUTRAL_RST;
      cfg_q.lost_timeout <= LOST_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o  = skid_full;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign sample_fire = in_fire && (action_e'(action_i) == ACT_SAMPLE);
  assign read_fire   = in_fire && (action_e'(action_i) == ACT_READ);

  assign levels = {level_d_i, level_c_i, level_b_i, level_a_i};

  for (genvar i = 0; i < PIN_FIELDS; i++) begin : g_lane
    if (i < LANES) begin : g_built
      rcpw_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .sample_i (sample_fire),
        .now_us_i (now_us_i),
        .level_i  (levels[i]),
        .cfg_i    (cfg_q),
        .res_o    (lane_res[i])
      );
    end else begin : g_absent
      // missing lane reports neutral and never counts as lost
      assign lane_res[i].lost  = 1'b0;
      assign lane_res[i].width = cfg_q.neutral;
    end
  end

  rcpw_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (read_fire),
    .lane_res_i  (lane_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .skid_full_o (skid_full),
    .result_o    (result)
  );

  assign width_a_o = result.width[0];
  assign width_b_o = result.width[1];
  assign width_c_o = result.width[2];
  assign width_d_o = result.width[3];
  assign healthy_o = result.healthy;

endmodule

// ----- design/rcpw_checker.sv -----
module rcpw_sva (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic action_i,
  input logic out_valid_o,
  input logic out_stall_i
);

  // a stalled item stays presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a read taken into an empty output shows up on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i && !out_valid_o |=> out_valid_o)
    else $error("read item did not produce a result");

  // a new result only follows an accepted read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && action_i))
    else $error("result without a read item");

  // input backpressure only builds up behind a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

endmodule

bind rc_pulse_width_capture rcpw_sva u_rcpw_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
